[rtl/ctc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants of the cycle-counter to nanosecond timecounter.
// ----------------------------------------------------------------------------
package ctc_pkg;

    // Field and register widths
    localparam int TS_W          = 64;
    localparam int HALF_W        = TS_W / 2;
    localparam int CV_W          = 32;
    localparam int CTC_COUNTER_W = 32;
    localparam int MULT_W        = 32;
    localparam int SHIFT_W       = 6;
    localparam int DIVISOR_W     = 8;

    // Register reset values
    localparam logic [MULT_W-1:0]    MULT_RST    = 32'd2048;
    localparam logic [SHIFT_W-1:0]   SHIFT_RST   = 6'd10;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RST = 8'd1;
    localparam logic [TS_W-1:0]      MAXC_RST    = 64'd9007199254740991;
    localparam logic [TS_W-1:0]      MAXN_RST    = 64'd18014398509481982;

    // APB port
    localparam int CFG_IDX_W  = 3;
    localparam int APB_ADDR_W = CFG_IDX_W + 3;
    localparam int APB_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MULT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_CYCLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_NSEC   = 3'd4;

    // Operation codes
    localparam logic [1:0] OP_SET_TIME = 2'd0;
    localparam logic [1:0] OP_SAMPLE   = 2'd1;
    localparam logic [1:0] OP_CONVERT  = 2'd2;

    // Divider sequencing: one quotient bit per cycle
    localparam int DIV_STEPS = TS_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [MULT_W-1:0]    mult;
        logic [SHIFT_W-1:0]   shift;
        logic [DIVISOR_W-1:0] divisor;
        logic [TS_W-1:0]      chunk_cycles;
        logic [TS_W-1:0]      chunk_nsec;
    } scl_cfg_t;

    typedef struct packed {
        logic            done;
        logic [TS_W-1:0] ns;
    } scl_status_t;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_DIV,
        SC_MUL,
        SC_SHIFT,
        SC_FINISH
    } scl_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_WRAP,
        T_SCALE,
        T_SUM,
        T_PUSH
    } top_state_t;

endpackage
`default_nettype wire

[rtl/ctc_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_scale
// Cycle to nanosecond scaling engine: one shared restoring divider and one
// 32x32 multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
module ctc_scale
    import ctc_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire scl_cfg_t        cfg,
    input  wire logic            start,
    input  wire logic [TS_W-1:0] cyc,
    output scl_status_t          status
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(5);

    scl_state_t        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              pass_reg, pass_next;
    logic              done_reg, done_next;
    logic [TS_W-1:0]   quo_reg, quo_next;
    logic [TS_W-1:0]   rem_reg, rem_next;
    logic [TS_W-1:0]   chunk_reg, chunk_next;
    logic [TS_W-1:0]   sc_reg, sc_next;
    logic [TS_W-1:0]   prod_reg, prod_next;
    logic [TS_W-1:0]   ns_reg, ns_next;

    logic [TS_W-1:0]   den;
    logic [TS_W:0]     shifted;
    logic [TS_W:0]     diff;
    logic              ge;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [TS_W-1:0]   mul_p;

    // Divider step: first pass by the chunk size, second by divisor
    assign den     = pass_reg ? {{(TS_W-DIVISOR_W){1'b0}}, cfg.divisor} : cfg.chunk_cycles;
    assign shifted = {rem_reg, quo_reg[TS_W-1]};
    assign ge      = shifted >= {1'b0, den};
    assign diff    = shifted - {1'b0, den};

    always_comb begin
        case (cnt_reg[2:0])
            3'd0: begin
                mul_a = quo_reg[HALF_W-1:0];
                mul_b = cfg.chunk_nsec[HALF_W-1:0];
            end
            3'd1: begin
                mul_a = quo_reg[HALF_W-1:0];
                mul_b = cfg.chunk_nsec[TS_W-1:HALF_W];
            end
            3'd2: begin
                mul_a = quo_reg[TS_W-1:HALF_W];
                mul_b = cfg.chunk_nsec[HALF_W-1:0];
            end
            3'd3: begin
                mul_a = rem_reg[HALF_W-1:0];
                mul_b = cfg.mult;
            end
            3'd4: begin
                mul_a = rem_reg[TS_W-1:HALF_W];
                mul_b = cfg.mult;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        done_next  = 1'b0;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        sc_next    = sc_reg;
        prod_next  = prod_reg;
        ns_next    = ns_reg;
        case (state_reg)
            SC_IDLE: begin
                if (start) begin
                    cnt_next   = '0;
                    pass_next  = 1'b0;
                    chunk_next = '0;
                    sc_next    = '0;
                    // skip the chunk divide when chunking is off or the count is already below one chunk
                    if (cfg.chunk_cycles != '0 && cyc >= cfg.chunk_cycles) begin
                        quo_next   = cyc;
                        rem_next   = '0;
                        state_next = SC_DIV;
                    end else begin
                        quo_next   = '0;
                        rem_next   = cyc;
                        state_next = SC_MUL;
                    end
                end
            end
            SC_DIV: begin
                quo_next = {quo_reg[TS_W-2:0], ge};
                rem_next = ge ? diff[TS_W-1:0] : shifted[TS_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST) begin
                    cnt_next   = '0;
                    state_next = pass_reg ? SC_FINISH : SC_MUL;
                end
            end
            SC_MUL: begin
                // product of step n lands in prod_reg, accumulated at step n+1
                prod_next = mul_p;
                cnt_next  = cnt_reg + 1'b1;
                case (cnt_reg[2:0])
                    3'd1:       chunk_next = chunk_reg + prod_reg;
                    3'd2, 3'd3: chunk_next = chunk_reg +
                                             {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                    3'd4:       sc_next    = sc_reg + prod_reg;
                    3'd5:       sc_next    = sc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                    default:    ;
                endcase
                if (cnt_reg == MUL_LAST) begin
                    cnt_next   = '0;
                    state_next = SC_SHIFT;
                end
            end
            SC_SHIFT: begin
                quo_next = sc_reg >> cfg.shift;
                if (cfg.divisor > DIVISOR_W'(1)) begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    pass_next  = 1'b1;
                    state_next = SC_DIV;
                end else begin
                    state_next = SC_FINISH;
                end
            end
            SC_FINISH: begin
                ns_next    = chunk_reg + quo_reg;
                done_next  = 1'b1;
                state_next = SC_IDLE;
            end
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
            pass_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        chunk_reg <= chunk_next;
        sc_reg    <= sc_next;
        prod_reg  <= prod_next;
        ns_reg    <= ns_next;
    end

    assign status.done = done_reg;
    assign status.ns   = ns_reg;

endmodule
`default_nettype wire

[rtl/cycle_counter_to_ns_timecounter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Item flow: set time and the reserved code go straight to the output stage;
//   convert and sample run the scaling engine, with a divider pass when the cycle count
//   reaches one chunk and one more when divisor is above one (one quotient bit per cycle).
// Throughput: one item at a time; the next item is taken in the cycle after the result
//   is registered, while the result itself may still be waiting at the output.
// Reset (aresetn low, synchronous): registers back to defaults, time state cleared.
// ----------------------------------------------------------------------------
// cycle_counter_to_ns_timecounter_core
// Turns a free-running cycle counter into 64-bit nanosecond time: set time,
// sample advance and captured timestamp conversion, configured over an APB register port.
// ----------------------------------------------------------------------------
module cycle_counter_to_ns_timecounter_core
    import ctc_pkg::*;
#(
    parameter int COUNTER_WIDTH = CTC_COUNTER_W
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // input items
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_operation,
    input  wire logic [CV_W-1:0]       s_counter_value,
    input  wire logic [TS_W-1:0]       s_time_value,
    // result items
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [TS_W-1:0]       m_time_ns
);

    localparam int CW = COUNTER_WIDTH;

    // ---------------------------------------------------------------- registers
    logic [MULT_W-1:0]    mult_reg;
    logic [SHIFT_W-1:0]   shift_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [TS_W-1:0]      chunk_cycles_reg;
    logic [TS_W-1:0]      chunk_nsec_reg;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg         <= MULT_RST;
            shift_reg        <= SHIFT_RST;
            divisor_reg      <= DIVISOR_RST;
            chunk_cycles_reg <= MAXC_RST;
            chunk_nsec_reg   <= MAXN_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_MULT:         mult_reg         <= pwdata[MULT_W-1:0];
                REG_SHIFT:        shift_reg        <= pwdata[SHIFT_W-1:0];
                REG_DIVISOR:      divisor_reg      <= pwdata[DIVISOR_W-1:0];
                REG_CHUNK_CYCLES: chunk_cycles_reg <= pwdata;
                REG_CHUNK_NSEC:   chunk_nsec_reg   <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MULT:         prdata = {{(APB_DATA_W-MULT_W){1'b0}}, mult_reg};
            REG_SHIFT:        prdata = {{(APB_DATA_W-SHIFT_W){1'b0}}, shift_reg};
            REG_DIVISOR:      prdata = {{(APB_DATA_W-DIVISOR_W){1'b0}}, divisor_reg};
            REG_CHUNK_CYCLES: prdata = chunk_cycles_reg;
            REG_CHUNK_NSEC:   prdata = chunk_nsec_reg;
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- scaling engine
    scl_cfg_t    scl_cfg;
    scl_status_t scl_status;
    logic        start_reg, start_next;
    logic [TS_W-1:0] scale_cyc_reg, scale_cyc_next;

    assign scl_cfg.mult         = mult_reg;
    assign scl_cfg.shift        = shift_reg;
    assign scl_cfg.divisor      = divisor_reg;
    assign scl_cfg.chunk_cycles = chunk_cycles_reg;
    assign scl_cfg.chunk_nsec   = chunk_nsec_reg;

    ctc_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (scl_cfg),
        .start   (start_reg),
        .cyc     (scale_cyc_reg),
        .status  (scl_status)
    );

    // ---------------------------------------------------------------- time state
    top_state_t      state_reg, state_next;
    logic [CW-1:0]   last_count_reg, last_count_next;
    logic [TS_W-1:0] total_reg, total_next;
    logic [TS_W-1:0] elapsed_reg, elapsed_next;
    logic [TS_W-1:0] wrap_reg, wrap_next;
    logic [TS_W-1:0] base_reg, base_next;
    logic [1:0]      op_reg, op_next;
    logic            neg_reg, neg_next;
    logic [TS_W-1:0] tmp_reg, tmp_next;
    logic [TS_W-1:0] res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    logic [TS_W-1:0] m_time_ns_reg, m_time_ns_next;

    // Counter value at the counter's own width: truncate or zero-extend
    logic [CW+CV_W-1:0] cv_wide;
    logic [CW-1:0]      cv_c;
    logic [CW-1:0]      delta_fwd;
    logic [CW-1:0]      delta_bwd;

    assign cv_wide   = {{CW{1'b0}}, s_counter_value};
    assign cv_c      = cv_wide[CW-1:0];
    assign delta_fwd = cv_c - last_count_reg;
    assign delta_bwd = last_count_reg - cv_c;

    assign s_ready = (state_reg == T_IDLE);

    always_comb begin
        state_next      = state_reg;
        last_count_next = last_count_reg;
        total_next      = total_reg;
        elapsed_next    = elapsed_reg;
        wrap_next       = wrap_reg;
        base_next       = base_reg;
        op_next         = op_reg;
        neg_next        = neg_reg;
        tmp_next        = tmp_reg;
        res_next        = res_reg;
        start_next      = 1'b0;
        scale_cyc_next  = scale_cyc_reg;
        m_valid_next    = m_valid_reg;
        m_time_ns_next  = m_time_ns_reg;

        // drop the result once the sink takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            T_IDLE: begin
                if (s_valid) begin
                    op_next = s_operation;
                    case (s_operation)
                        OP_SET_TIME: begin
                            last_count_next = cv_c;
                            total_next      = '0;
                            elapsed_next    = '0;
                            wrap_next       = '0;
                            base_next       = s_time_value;
                            res_next        = s_time_value;
                            state_next      = T_PUSH;
                        end
                        OP_SAMPLE: begin
                            // advance the cycle total by the wrapped delta
                            last_count_next = cv_c;
                            total_next      = total_reg + {{(TS_W-CW){1'b0}}, delta_fwd};
                            state_next      = T_WRAP;
                        end
                        OP_CONVERT: begin
                            // a delta at or above half range means the timestamp lies in the past
                            neg_next       = delta_fwd[CW-1];
                            scale_cyc_next = {{(TS_W-CW){1'b0}},
                                              delta_fwd[CW-1] ? delta_bwd : delta_fwd};
                            start_next     = 1'b1;
                            state_next     = T_SCALE;
                        end
                        default: begin
                            // reserved code: report current time, change nothing
                            res_next   = base_reg + elapsed_reg;
                            state_next = T_PUSH;
                        end
                    endcase
                end
            end
            T_WRAP: begin
                // move one whole chunk into the wrap total when the cycle total reaches it
                if (chunk_cycles_reg != '0 && total_reg >= chunk_cycles_reg) begin
                    total_next     = total_reg - chunk_cycles_reg;
                    wrap_next      = wrap_reg + chunk_nsec_reg;
                    scale_cyc_next = total_reg - chunk_cycles_reg;
                end else begin
                    scale_cyc_next = total_reg;
                end
                start_next = 1'b1;
                state_next = T_SCALE;
            end
            T_SCALE: begin
                if (scl_status.done) begin
                    if (op_reg == OP_SAMPLE) begin
                        elapsed_next = wrap_reg + scl_status.ns;
                        tmp_next     = wrap_reg + scl_status.ns;
                    end else if (neg_reg) begin
                        tmp_next = elapsed_reg - scl_status.ns;
                    end else begin
                        tmp_next = elapsed_reg + scl_status.ns;
                    end
                    state_next = T_SUM;
                end
            end
            T_SUM: begin
                res_next   = base_reg + tmp_reg;
                state_next = T_PUSH;
            end
            T_PUSH: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_time_ns_next = res_reg;
                    state_next     = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            last_count_reg <= '0;
            total_reg      <= '0;
            elapsed_reg    <= '0;
            wrap_reg       <= '0;
            base_reg       <= '0;
            start_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_count_reg <= last_count_next;
            total_reg      <= total_next;
            elapsed_reg    <= elapsed_next;
            wrap_reg       <= wrap_next;
            base_reg       <= base_next;
            start_reg      <= start_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        neg_reg       <= neg_next;
        tmp_reg       <= tmp_next;
        res_reg       <= res_next;
        scale_cyc_reg <= scale_cyc_next;
        m_time_ns_reg <= m_time_ns_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_time_ns = m_time_ns_reg;

endmodule
`default_nettype wire

[rtl/ctc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_checker
// Port-level checks on the timecounter core, bound to the top level.
// ----------------------------------------------------------------------------
module ctc_checker
    import ctc_pkg::*;
(
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire logic [TS_W-1:0] m_time_ns,
    input wire logic            pready
);

    // one item at a time: ready drops after every accepted item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready still high after an accepted item");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_time_ns))
        else $error("stalled result changed");

    a_apb_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port inserted a wait state");

endmodule

bind cycle_counter_to_ns_timecounter_core ctc_checker u_ctc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_time_ns (m_time_ns),
    .pready    (pready)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cycle-counter to nanosecond timecounter: a short
// scripted run of edge cases, then randomised phases under varied register
// settings and idling, every result checked against an in-bench time model or typed value.
// ----------------------------------------------------------------------------
module tb_top;
    import ctc_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;  // no state change, reports current time
    localparam int CYCLE_LIMIT    = 2000000;    // hard stop, far beyond the slowest run
    localparam int HOLD_CYCLES    = 300;        // long receiver hold-off for back-pressure
    localparam int TAIL_CYCLES    = 160;        // tail wait, longer than the slowest item
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 95;
    localparam int MAX_REPORTS    = 10;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_operation     = '0;
    logic [CV_W-1:0]       s_counter_value = '0;
    logic [TS_W-1:0]       s_time_value    = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [TS_W-1:0]       m_time_ns;

    always #10 aclk = ~aclk;

    cycle_counter_to_ns_timecounter_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_counter_value (s_counter_value),
        .s_time_value    (s_time_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_time_ns       (m_time_ns)
    );

    // ------------------------------------------------------------------------
    // Time model: register copy, counter state and the expected time queue
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [CV_W-1:0] last_count;
        logic [TS_W-1:0] total_cycles;
        logic [TS_W-1:0] elapsed_ns;
        logic [TS_W-1:0] wrap_ns;
        logic [TS_W-1:0] base_ns;
    } tc_state_t;

    scl_cfg_t        tcfg;
    tc_state_t       tc;
    logic [TS_W-1:0] expected_ns[$];

    int items_sent     = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int chunk_carries  = 0;
    int past_converts  = 0;
    int cycle_count    = 0;
    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    // Cycles to ns: whole chunks first, then the scaled remainder.
    // The product wraps at 64 bits before the shift; a zero divisor acts as one.
    function automatic logic [TS_W-1:0] cycles_to_ns(input logic [TS_W-1:0] cyc);
        logic [TS_W-1:0] ns;
        logic [TS_W-1:0] prod;
        logic [TS_W-1:0] div;
        ns  = '0;
        div = (tcfg.divisor == '0) ? 64'd1 : {56'd0, tcfg.divisor};
        if (tcfg.chunk_cycles != '0) begin
            ns  = (cyc / tcfg.chunk_cycles) * tcfg.chunk_nsec;
            cyc = cyc % tcfg.chunk_cycles;
        end
        prod = cyc * {32'd0, tcfg.mult};
        return ns + ((prod >> tcfg.shift) / div);
    endfunction

    // Advance the model by one item and return the time it reports.
    function automatic logic [TS_W-1:0] advance_timecounter(input logic [1:0] op,
                                                            input logic [CV_W-1:0] cv,
                                                            input logic [TS_W-1:0] tv);
        logic [CV_W-1:0] fwd;
        logic [CV_W-1:0] back;
        fwd  = cv - tc.last_count;
        back = tc.last_count - cv;
        case (op)
            OP_SET_TIME: begin
                tc = '{last_count: cv, base_ns: tv, default: '0};
                return tv;
            end
            OP_SAMPLE: begin
                tc.last_count   = cv;
                tc.total_cycles = tc.total_cycles + {32'd0, fwd};
                // move one whole chunk into the kept wrap total
                if (tcfg.chunk_cycles != '0 && tc.total_cycles >= tcfg.chunk_cycles) begin
                    tc.total_cycles = tc.total_cycles - tcfg.chunk_cycles;
                    tc.wrap_ns      = tc.wrap_ns + tcfg.chunk_nsec;
                    chunk_carries++;
                end
                tc.elapsed_ns = tc.wrap_ns + cycles_to_ns(tc.total_cycles);
                return tc.base_ns + tc.elapsed_ns;
            end
            OP_CONVERT: begin
                // at or beyond half the counter range the capture lies in the past
                if (fwd > 32'h7FFF_FFFF) begin
                    past_converts++;
                    return tc.base_ns + tc.elapsed_ns - cycles_to_ns({32'd0, back});
                end
                return tc.base_ns + tc.elapsed_ns + cycles_to_ns({32'd0, fwd});
            end
            default: return tc.base_ns + tc.elapsed_ns;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, a long hold-off on request, and checking
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(input string what, input logic [TS_W-1:0] want,
                                          input logic [TS_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: expected time_ns %0d (0x%h), got %0d (0x%h)",
                     $realtime, what, want, want, got, got);
    endfunction

    logic [TS_W-1:0] head_ns;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            // compare every accepted result with the oldest waiting expectation
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_ns.size() == 0) begin
                    note_mismatch("result with nothing expected", '0, m_time_ns);
                end else begin
                    head_ns = expected_ns.pop_front();
                    if (m_time_ns !== head_ns)
                        note_mismatch("time_ns mismatch", head_ns, m_time_ns);
                end
            end
            // hold off for a long stretch when asked, else stall at random
            if (hold_served != hold_asked) begin
                hold_served <= hold_asked;
                hold_left   <= HOLD_CYCLES;
                m_ready     <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_ns.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------------
    function automatic int sender_gap();
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct)
            gap++;
        return gap;
    endfunction

    // Offer one item, hold it until taken, then log its expected time.
    // Valid is left high so a back-to-back item follows without a gap.
    task automatic push_item(input logic [1:0] op, input logic [CV_W-1:0] cv,
                             input logic [TS_W-1:0] tv, input bit typed,
                             input logic [TS_W-1:0] want);
        int gap;
        logic [TS_W-1:0] ns;
        gap = sender_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_counter_value <= cv;
        s_time_value    <= tv;
        do @(posedge aclk); while (!s_ready);
        ns = advance_timecounter(op, cv, tv);
        expected_ns.push_back(typed ? want : ns);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic wait_drain();
        if (s_valid)
            s_valid <= 1'b0;
        while (expected_ns.size() != 0)
            @(posedge aclk);
    endtask

    // Setup then access cycle; the register takes the value at the access edge.
    // The bus returns to idle before the next transfer.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TS_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MULT:         tcfg.mult         = val[MULT_W-1:0];
            REG_SHIFT:        tcfg.shift        = val[SHIFT_W-1:0];
            REG_DIVISOR:      tcfg.divisor      = val[DIVISOR_W-1:0];
            REG_CHUNK_CYCLES: tcfg.chunk_cycles = val;
            REG_CHUNK_NSEC:   tcfg.chunk_nsec   = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Scripted edge cases. Register rows are applied once the block is idle;
    // item rows with a typed value are checked against that value directly.
    // ------------------------------------------------------------------------
    typedef enum bit { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [2:0]      sel;    // operation code or register index
        logic [CV_W-1:0] cv;
        logic [TS_W-1:0] val;    // time value or register value
        bit              typed;
        logic [TS_W-1:0] want;
    } script_row_t;

    script_row_t edge_script [31] = '{
        // straight after reset nothing has elapsed
        '{ROW_ITEM, {1'b0, OP_CONVERT},  32'h0,         64'h0,     1'b1, 64'h0},
        '{ROW_ITEM, {1'b0, OP_SAMPLE},   32'h0,         64'h0,     1'b1, 64'h0},
        '{ROW_ITEM, {1'b0, OP_RESERVED}, 32'h0,         64'h0,     1'b1, 64'h0},
        // set time reports the new base
        '{ROW_ITEM, {1'b0, OP_SET_TIME}, 32'hFFFF_FFFF, '1,        1'b1, '1},
        '{ROW_ITEM, {1'b0, OP_SET_TIME}, 32'hFFFF_FFF0, 64'h0,     1'b1, 64'h0},
        // counter wraps through zero, then both sides of the half-range edge
        '{ROW_ITEM, {1'b0, OP_SAMPLE},   32'h0000_0010, 64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_CONVERT},  32'h8000_000F, 64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_CONVERT},  32'h8000_0010, '1,        1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_CONVERT},  32'h0000_0008, 64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_SAMPLE},   32'hFFFF_FFFF, 64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_RESERVED}, 32'h0000_1234, '1,        1'b0, 64'h0},
        // tiny chunk so a sample carries into the wrap total
        '{ROW_REG,  REG_CHUNK_CYCLES,    32'h0,         64'd100,   1'b0, 64'h0},
        '{ROW_REG,  REG_CHUNK_NSEC,      32'h0,         '1,        1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_SET_TIME}, 32'h0,         64'd1000,  1'b1, 64'd1000},
        '{ROW_ITEM, {1'b0, OP_SAMPLE},   32'd250,       64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_CONVERT},  32'd1000,      64'h0,     1'b0, 64'h0},
        // chunking off, product wraps, zero divisor
        '{ROW_REG,  REG_CHUNK_CYCLES,    32'h0,         64'h0,     1'b0, 64'h0},
        '{ROW_REG,  REG_MULT,            32'h0,         64'hFFFF_FFFF, 1'b0, 64'h0},
        '{ROW_REG,  REG_SHIFT,           32'h0,         64'h0,     1'b0, 64'h0},
        '{ROW_REG,  REG_DIVISOR,         32'h0,         64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_SAMPLE},   32'hFFFF_FFFF, 64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_CONVERT},  32'h0,         64'h0,     1'b0, 64'h0},
        // opposite extremes: smallest chunk, largest shift and divisor
        '{ROW_REG,  REG_MULT,            32'h0,         64'h1,     1'b0, 64'h0},
        '{ROW_REG,  REG_SHIFT,           32'h0,         64'd63,    1'b0, 64'h0},
        '{ROW_REG,  REG_DIVISOR,         32'h0,         64'd255,   1'b0, 64'h0},
        '{ROW_REG,  REG_CHUNK_CYCLES,    32'h0,         64'h1,     1'b0, 64'h0},
        '{ROW_REG,  REG_CHUNK_NSEC,      32'h0,         64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_SAMPLE},   32'd12345,     64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_CONVERT},  32'd12422,     64'h0,     1'b0, 64'h0},
        '{ROW_ITEM, {1'b0, OP_SET_TIME}, 32'hABCD_0123, 64'h0123_4567_89AB_CDEF,
          1'b1, 64'h0123_4567_89AB_CDEF},
        '{ROW_ITEM, {1'b0, OP_SAMPLE},   32'hABCD_0124, 64'h0,     1'b0, 64'h0}
    };

    // ------------------------------------------------------------------------
    // Random phases
    // ------------------------------------------------------------------------
    function automatic logic [TS_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pick the register set for a phase: reset values, a realistic clock,
    // both extremes, chunking off, then fully random settings.
    task automatic load_settings(input int ph);
        logic [TS_W-1:0] mc;
        case (ph)
            0: mc = MAXC_RST;
            1: mc = ({32'd0, $urandom} << $urandom_range(0, 4)) | 64'h1_0000_0000;
            2: mc = '1;
            3: mc = 64'd1;
            4: mc = '0;
            default: begin
                case ($urandom_range(2))
                    0:       mc = 64'($urandom_range(1, 65535));
                    1:       mc = rand64() >> $urandom_range(20, 40);
                    default: mc = rand64();
                endcase
            end
        endcase
        wait_drain();
        case (ph)
            0: begin
                reg_write(REG_MULT,    64'(MULT_RST));
                reg_write(REG_SHIFT,   64'(SHIFT_RST));
                reg_write(REG_DIVISOR, 64'(DIVISOR_RST));
                reg_write(REG_CHUNK_NSEC, MAXN_RST);
            end
            1: begin
                reg_write(REG_MULT,    64'($urandom_range(32'h0010_0000, 32'h8000_0000)));
                reg_write(REG_SHIFT,   64'($urandom_range(16, 31)));
                reg_write(REG_DIVISOR, 64'd1);
                reg_write(REG_CHUNK_NSEC, rand64());
            end
            2: begin
                reg_write(REG_MULT,    64'hFFFF_FFFF);
                reg_write(REG_SHIFT,   64'd63);
                reg_write(REG_DIVISOR, 64'd255);
                reg_write(REG_CHUNK_NSEC, '1);
            end
            3: begin
                reg_write(REG_MULT,    64'd1);
                reg_write(REG_SHIFT,   64'd0);
                reg_write(REG_DIVISOR, 64'd1);
                reg_write(REG_CHUNK_NSEC, 64'd0);
            end
            4: begin
                reg_write(REG_MULT,    64'($urandom));
                reg_write(REG_SHIFT,   64'($urandom_range(63)));
                reg_write(REG_DIVISOR, 64'd0);
                reg_write(REG_CHUNK_NSEC, rand64());
            end
            default: begin
                reg_write(REG_MULT,    64'($urandom));
                reg_write(REG_SHIFT,   64'($urandom_range(63)));
                reg_write(REG_DIVISOR, 64'($urandom_range(255)));
                reg_write(REG_CHUNK_NSEC, rand64());
            end
        endcase
        reg_write(REG_CHUNK_CYCLES, mc);
    endtask

    // Mostly samples walking forward and captures near the last sample,
    // with occasional set-time, reserved codes and wild counter values.
    task automatic run_phase(input int ph);
        int              pick;
        logic [1:0]      op;
        logic [CV_W-1:0] cv;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long receiver hold-off while items keep coming: the block fills up
            if (ph == 2 && i == PHASE_ITEMS / 3)
                hold_asked <= hold_asked + 1;
            // sender pauses until everything has come back
            if (ph == 6 && i == PHASE_ITEMS / 2)
                wait_drain();
            pick = $urandom_range(99);
            if (pick < 8) begin
                op = OP_SET_TIME;
                cv = $urandom;
            end else if (pick < 12) begin
                op = OP_RESERVED;
                cv = $urandom;
            end else if (pick < 57) begin
                op = OP_SAMPLE;
                case ($urandom_range(3))
                    0:       cv = tc.last_count;
                    1:       cv = tc.last_count + $urandom_range(1, 4096);
                    2:       cv = tc.last_count + $urandom_range(0, 32'h0100_0000);
                    default: cv = $urandom;
                endcase
            end else begin
                op = OP_CONVERT;
                case ($urandom_range(2))
                    0:       cv = tc.last_count + $urandom_range(0, 4096);
                    1:       cv = tc.last_count - $urandom_range(1, 4096);
                    default: cv = $urandom;
                endcase
            end
            push_item(op, cv, rand64(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        tcfg = '{mult: MULT_RST, shift: SHIFT_RST, divisor: DIVISOR_RST,
                 chunk_cycles: MAXC_RST, chunk_nsec: MAXN_RST};
        tc   = '0;

        // hold reset, then release on a clock edge
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // scripted edge cases, no idling on either side
        for (int r = 0; r < $size(edge_script); r++) begin
            if (edge_script[r].kind == ROW_REG) begin
                wait_drain();
                reg_write(edge_script[r].sel, edge_script[r].val);
            end else begin
                push_item(edge_script[r].sel[1:0], edge_script[r].cv, edge_script[r].val,
                          edge_script[r].typed, edge_script[r].want);
            end
        end

        // random phases: cycle through no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < PHASES; ph++) begin
            load_settings(ph);
            case (ph % 4)
                0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct <= 65; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct <= 0;  rx_stall_pct <= 65; end
                default: begin tx_idle_pct <= 31; rx_stall_pct <= 31; end
            endcase
            run_phase(ph);
        end

        // drain, then allow for a straggler
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d items over %0d register settings, %0d results checked",
                 items_sent, PHASES + 4, results_seen);
        $display("chunk carries %0d, past-timestamp conversions %0d, left waiting %0d",
                 chunk_carries, past_converts, expected_ns.size());
        if (mismatch_count == 0 && expected_ns.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
